/* hdl/stbe_pkg.sv */
// Shared constants and types for the sparse tile bitmask encoder.
// No dependencies; imported by the top level.
package stbe_pkg;

  // Tile geometry and field widths
  localparam int TILE_WIDTH  = 16;
  localparam int LANE_BITS   = $clog2(TILE_WIDTH);
  localparam int POP_BITS    = $clog2(TILE_WIDTH + 1);
  localparam int ROW_BITS    = 16;
  localparam int COL_BITS    = 16;
  localparam int OFFSET_BITS = 32;
  localparam int VALUE_BITS  = 32;
  localparam int CFG_BITS    = 16;
  localparam int INDEX_BITS  = 8;

  // Output word layout: row, first column, mask, offset, value
  localparam int TDATA_BITS = ROW_BITS + COL_BITS + TILE_WIDTH + OFFSET_BITS + VALUE_BITS;

  // Configuration register indexes
  localparam logic [INDEX_BITS-1:0] REG_NUM_COLS = INDEX_BITS'(0);
  localparam logic [INDEX_BITS-1:0] REG_NUM_ROWS = INDEX_BITS'(1);

  // Reset values of the configuration registers
  localparam logic [CFG_BITS-1:0] NUM_COLS_RESET = CFG_BITS'(16);
  localparam logic [CFG_BITS-1:0] NUM_ROWS_RESET = CFG_BITS'(1);

  typedef logic [TILE_WIDTH-1:0] lane_mask_t;
  typedef logic [LANE_BITS-1:0]  lane_t;

  // Tile drain sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HDR,
    ST_READ,
    ST_VAL
  } drain_state_t;

endpackage

/* hdl/stbe_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; holds the open tile's elements for the encoder.
module stbe_ram #(
  parameter int WIDTH     = 32,
  parameter int DEPTH     = 16,
  parameter int ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [WIDTH-1:0]     wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data, held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/sparse_tile_bitmask_encoder.sv */
// Sparse tile bitmask encoder: cuts rows into 16-lane tiles, emits header and values nonzero in bits 30:0.
// Header: the closing word's tile is captured, then the header is registered into the output.
// Throughput: one input word per cycle inside a tile; the word that closes a nonzero tile
// stalls input while the header is loaded and the tile RAM is read for each nonzero value
// in turn, and while the result side holds back. An all-zero tile does not stall.
// Reset: counters, mask and offset clear, num_cols = 16, num_rows = 1; tile RAM not cleared.
module sparse_tile_bitmask_encoder (
  input  logic                                 clk,
  input  logic                                 rst,
  // Input words
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [stbe_pkg::VALUE_BITS-1:0]      s_tdata,   // value
  // Result words
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [stbe_pkg::TDATA_BITS-1:0]      m_tdata,   // row_index, tile_column, bitmask,
                                                          // value_offset, nonzero_value
  output logic                                 m_tuser,   // is_header
  output logic                                 m_tlast,   // last
  // Configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [stbe_pkg::INDEX_BITS-1:0]      cfg_index,
  input  logic [stbe_pkg::CFG_BITS-1:0]        cfg_data
);

  import stbe_pkg::*;

  drain_state_t state, state_next;

  logic [CFG_BITS-1:0]    num_cols;
  logic [CFG_BITS-1:0]    num_rows;
  logic [COL_BITS-1:0]    col_count;
  logic [ROW_BITS-1:0]    row_count;
  logic [COL_BITS-1:0]    tile_start;
  logic [OFFSET_BITS-1:0] value_count;
  lane_mask_t             lane_mask;

  // Snapshot of the closed tile being drained
  lane_mask_t             drain_mask;
  logic [ROW_BITS-1:0]    drain_row;
  logic [COL_BITS-1:0]    drain_col;
  logic [OFFSET_BITS-1:0] drain_offset;

  logic                   accept;
  logic                   out_free;
  lane_t                  lane;
  logic                   nonzero;
  lane_mask_t             mask_new;
  logic [CFG_BITS:0]      eff_cols;
  logic [CFG_BITS:0]      eff_rows;
  logic [COL_BITS:0]      col_inc;
  logic [ROW_BITS:0]      row_inc;
  logic                   row_end;
  logic                   matrix_end;
  logic                   tile_close;
  logic [POP_BITS-1:0]    pop;
  lane_mask_t             low_onehot;
  lane_t                  low_lane;
  lane_mask_t             mask_rest;

  logic                   ram_rd_en;
  logic [VALUE_BITS-1:0]  ram_rd_data;
  logic                   load_hdr;
  logic                   load_val;

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_cols <= NUM_COLS_RESET;
      num_rows <= NUM_ROWS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_NUM_COLS) begin
        num_cols <= cfg_data;
      end else if (cfg_index == REG_NUM_ROWS) begin
        num_rows <= cfg_data;
      end
    end
  end

  // Zero register value means a full 2^16 size
  assign eff_cols = (num_cols == '0) ? {1'b1, {CFG_BITS{1'b0}}} : {1'b0, num_cols};
  assign eff_rows = (num_rows == '0) ? {1'b1, {CFG_BITS{1'b0}}} : {1'b0, num_rows};

  // Lane and tile close decode for the incoming word
  always_comb begin
    lane       = LANE_BITS'(col_count - tile_start);
    nonzero    = (s_tdata[VALUE_BITS-2:0] != '0);
    mask_new   = lane_mask | (lane_mask_t'(nonzero) << lane);
    col_inc    = {1'b0, col_count} + (COL_BITS+1)'(1);
    row_inc    = {1'b0, row_count} + (ROW_BITS+1)'(1);
    row_end    = (col_inc >= eff_cols);
    matrix_end = row_end && (row_inc >= eff_rows);
    tile_close = (lane == lane_t'(TILE_WIDTH - 1)) || row_end;
  end

  // Count nonzero lanes of the closing tile
  always_comb begin
    pop = '0;
    for (int k = 0; k < TILE_WIDTH; k++) begin
      pop = pop + POP_BITS'(mask_new[k]);
    end
  end

  // Position counters, open tile mask and running offset
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count   <= '0;
      row_count   <= '0;
      tile_start  <= '0;
      value_count <= '0;
      lane_mask   <= '0;
    end else if (accept) begin
      if (row_end) begin
        col_count  <= '0;
        tile_start <= '0;
        lane_mask  <= '0;
        row_count  <= matrix_end ? '0 : row_inc[ROW_BITS-1:0];
      end else begin
        col_count <= col_inc[COL_BITS-1:0];
        if (tile_close) begin
          tile_start <= col_inc[COL_BITS-1:0];
          lane_mask  <= '0;
        end else begin
          lane_mask <= mask_new;
        end
      end
      if (matrix_end) begin
        value_count <= '0;
      end else if (tile_close) begin
        value_count <= value_count + OFFSET_BITS'(pop);
      end
    end
  end

  // Capture the closed tile; clear lanes as their values go out
  always_ff @(posedge clk) begin
    if (accept && tile_close) begin
      drain_mask   <= mask_new;
      drain_row    <= row_count;
      drain_col    <= tile_start;
      drain_offset <= value_count;
    end else if (load_val) begin
      drain_mask <= mask_rest;
    end
  end

  // Lowest remaining lane of the drained tile
  always_comb begin
    low_onehot = drain_mask & (~drain_mask + lane_mask_t'(1));
    mask_rest  = drain_mask & ~low_onehot;
    low_lane   = '0;
    for (int k = 0; k < TILE_WIDTH; k++) begin
      if (low_onehot[k]) begin
        low_lane = low_lane | lane_t'(k);
      end
    end
  end

  // Tile buffer; input stalls while draining, so writes and reads never overlap
  stbe_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (TILE_WIDTH)
  ) u_tile_ram (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (lane),
    .wr_data (s_tdata),
    .rd_en   (ram_rd_en),
    .rd_addr (low_lane),
    .rd_data (ram_rd_data)
  );

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && tile_close && (mask_new != '0)) begin
          state_next = ST_HDR;
        end
      end
      ST_HDR: begin
        if (out_free) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_VAL;
      end
      ST_VAL: begin
        if (out_free) begin
          state_next = (mask_rest == '0) ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_tready  = 1'b0;
    ram_rd_en = 1'b0;
    load_hdr  = 1'b0;
    load_val  = 1'b0;
    case (state)
      ST_IDLE: s_tready  = 1'b1;
      ST_HDR:  load_hdr  = out_free;
      ST_READ: ram_rd_en = 1'b1;
      ST_VAL:  load_val  = out_free;
      default: s_tready  = 1'b0;
    endcase
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_hdr || load_val) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_hdr) begin
      m_tdata <= {{VALUE_BITS{1'b0}}, drain_offset, drain_mask, drain_col, drain_row};
      m_tuser <= 1'b1;
      m_tlast <= 1'b0;
    end else if (load_val) begin
      m_tdata <= {ram_rd_data, {(TDATA_BITS - VALUE_BITS){1'b0}}};
      m_tuser <= 1'b0;
      m_tlast <= (mask_rest == '0);
    end
  end

endmodule
